@@ sv/frl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package frl_pkg;
  localparam int MaxRangesDefault = 256;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam logic [31:0] NoneValue = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        cmd;
    logic [30:0] alloc_size;
    logic [30:0] free_start;
    logic [30:0] free_stop;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] grant_start;
    logic signed [31:0] grant_stop;
  } resp_t;

  // Operation broadcast along the cell chain.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_TRIM   = 3'd1,
    OP_POP    = 3'd2,
    OP_INSERT = 3'd3,
    OP_UNION  = 3'd4,
    OP_MERGE  = 3'd5
  } op_t;

  // Bounds seen by every cell: lo is the freed start or the new head start.
  typedef struct packed {
    logic [30:0] lo;
    logic [30:0] hi;
  } bcast_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic        valid;
    logic [30:0] start;
    logic [30:0] stop;
  } link_t;
endpackage
`default_nettype wire

@@ sv/frl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One slot of the sorted range list. On an operation every cell computes its new
// content from its own entry and the entries of its two neighbors, so a shift
// moves the whole list left or right by one slot at once.
module frl_cell
  import frl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   first,
  input  op_t    op,
  input  bcast_t bc,
  input  link_t  left,
  input  link_t  right,
  output link_t  self,
  output logic   touch,
  output logic   overlap
);
  logic        valid;
  logic [30:0] start;
  logic [30:0] stop;
  logic        valid_next;
  logic [30:0] start_next;
  logic [30:0] stop_next;
  logic        own_below;
  logic        left_before;
  logic        anchor;

  always_comb begin
    own_below   = valid && (stop < bc.lo);
    // everything to the left lies below the freed range
    left_before = first || (left.valid && (left.stop < bc.lo));
    anchor      = valid && !own_below && left_before;
    touch       = valid && !own_below && (start <= bc.hi);
    overlap     = anchor && right.valid && (right.start <= stop);

    self       = '{valid: valid, start: start, stop: stop};
    valid_next = valid;
    start_next = start;
    stop_next  = stop;

    case (op)
      OP_TRIM: begin
        if (first) start_next = bc.lo;
      end
      OP_POP: begin
        valid_next = right.valid;
        start_next = right.start;
        stop_next  = right.stop;
      end
      OP_INSERT: begin
        if (!own_below) begin
          if (left_before) begin
            valid_next = 1'b1;
            start_next = bc.lo;
            stop_next  = bc.hi;
          end else begin
            // shift right
            valid_next = left.valid;
            start_next = left.start;
            stop_next  = left.stop;
          end
        end
      end
      OP_UNION: begin
        if (anchor) begin
          start_next = (start < bc.lo) ? start : bc.lo;
          stop_next  = (stop > bc.hi) ? stop : bc.hi;
        end
      end
      OP_MERGE: begin
        if (anchor) begin
          stop_next = (right.stop > stop) ? right.stop : stop;
        end else if (!own_below && !left_before) begin
          // close the gap left by the absorbed entry
          valid_next = right.valid;
          start_next = right.start;
          stop_next  = right.stop;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    start <= start_next;
    stop  <= stop_next;
  end
endmodule
`default_nettype wire

@@ sv/free_range_list_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Free range allocator: a sorted list of disjoint free ranges [start,stop) held in a
// chain of MAX_RANGES cells. An allocate serves from the head range; a free inserts
// its range and merges it with touching neighbors. A request that changes the list
// steps through accept, decode and chain step, merge check and result before the
// next acceptance; a rejected request or an empty free skips the merge check. A
// free stays in the merge check for each further entry it absorbs, since the chain
// closes the gap one slot a cycle. The result beat leaves an output register; a new
// request can be accepted while a stalled result waits, and the next result holds
// in its last step until the output register frees up.
module free_range_list_allocator
  import frl_pkg::*;
#(
  parameter int MAX_RANGES = MaxRangesDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output resp_t out_data
);
  localparam int CW = $clog2(MAX_RANGES + 1);

  typedef enum logic [1:0] {
    S_IDLE, S_DECODE, S_COMPACT, S_DONE
  } state_t;

  state_t        state;
  req_t          req;
  logic [CW-1:0] count;
  resp_t         res;
  resp_t         res_next;
  op_t           op;
  bcast_t        bc;
  logic [31:0]   want;
  logic          any_touch;
  logic          any_overlap;

  // links[0] and links[MAX_RANGES+1] are empty ends; cell g shows links[g+1].
  link_t links [MAX_RANGES+2];
  logic [MAX_RANGES-1:0] touch_vec;
  logic [MAX_RANGES-1:0] overlap_vec;

  assign links[0]            = '{valid: 1'b0, start: '0, stop: '0};
  assign links[MAX_RANGES+1] = '{valid: 1'b0, start: '0, stop: '0};

  genvar g;
  generate
    for (g = 0; g < MAX_RANGES; g++) begin : g_cell
      frl_cell u_cell (
        .clk(clk), .rst(rst), .first(g == 0), .op(op), .bc(bc),
        .left(links[g]), .right(links[g+2]), .self(links[g+1]),
        .touch(touch_vec[g]), .overlap(overlap_vec[g])
      );
    end
  endgenerate

  assign any_touch   = |touch_vec;
  assign any_overlap = |overlap_vec;
  assign want = {1'b0, links[1].start} + {1'b0, req.alloc_size};
  assign bc.lo = (req.cmd == CMD_ALLOC) ? want[30:0] : req.free_start;
  assign bc.hi = req.free_stop;

  always_comb begin
    op       = OP_NONE;
    res_next = '{status: ST_OK, grant_start: NoneValue, grant_stop: NoneValue};
    case (state)
      S_DECODE: begin
        if (req.cmd == CMD_ALLOC) begin
          if (req.alloc_size == '0) begin
            res_next.status = ST_INVALID;
          end else if (count == '0) begin
            res_next.status = ST_EMPTY;
          end else begin
            res_next.grant_start = {1'b0, links[1].start};
            if ({1'b0, links[1].stop} > want) begin
              res_next.grant_stop = want;
              op = OP_TRIM;
            end else begin
              res_next.grant_stop = {1'b0, links[1].stop};
              op = OP_POP;
            end
          end
        end else if (req.free_stop == '0 || req.free_stop < req.free_start) begin
          res_next.status = ST_INVALID;
        end else if (req.free_stop != req.free_start) begin
          if (any_touch) begin
            op = OP_UNION;
          end else if (count >= CW'(MAX_RANGES)) begin
            res_next.status = ST_FULL;
          end else begin
            op = OP_INSERT;
          end
        end
      end
      S_COMPACT: begin
        // absorb the next entry while it still touches the merged one
        if (req.cmd == CMD_FREE && any_overlap) op = OP_MERGE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res <= res_next;
          if (op == OP_POP) count <= count - CW'(1);
          if (op == OP_INSERT) count <= count + CW'(1);
          state <= (op == OP_NONE) ? S_DONE : S_COMPACT;
        end
        S_COMPACT: begin
          if (op == OP_MERGE) begin
            count <= count - CW'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);
endmodule
`default_nettype wire

@@ sv/frl_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module frl_props
  import frl_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input resp_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");
  a_free_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.grant_start == NoneValue)
    else $error("failed beat carries a grant");
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.grant_stop != NoneValue |->
      out_data.grant_stop > out_data.grant_start)
    else $error("grant empty");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken too early");
endmodule

bind free_range_list_allocator frl_props u_frl_props (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire
